/* sv/instance_normalization_macros.svh */
// Assertion macros used by the instance normalization controller.
`ifndef INSTANCE_NORMALIZATION_MACROS_SVH
`define INSTANCE_NORMALIZATION_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define INORM_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define INORM_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/inorm_pkg.sv */
// Types and constants shared by the instance normalization modules.
package inorm_pkg;

	localparam int unsigned DATA_W     = 16;
	localparam int unsigned EPS_W      = 16;
	localparam int unsigned QUOT_W     = 32;
	localparam int unsigned ROOT_W     = 32;
	localparam int unsigned FRAC_SHIFT = 11;
	localparam int unsigned SQRT_SHIFT = 30;
	localparam int unsigned QCLAMP_W   = 17;

	localparam logic [QCLAMP_W-1:0] Q_CLAMP   = 17'd100000;
	localparam logic [EPS_W-1:0]    EPS_RESET = 16'd1;
	localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic signed [DATA_W-1:0] scale_gamma;
		logic signed [DATA_W-1:0] shift_beta;
		logic                     last_of_instance;
	} sample_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] norm_value;
		logic                     last_in_run;
	} result_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P1,
		ST_DIVV,
		ST_VWAIT,
		ST_SQRT,
		ST_SWAIT,
		ST_DEN,
		ST_ERD,
		ST_ERAM,
		ST_ENUM,
		ST_EDIV,
		ST_EWAIT,
		ST_EOUT
	} state_t;

	typedef struct packed {
		logic load;
		logic p1_run;
		logic var_start;
		logic sqrt_start;
		logic den_load;
		logic e_rd;
		logic e_d;
		logic e_num;
		logic e_div;
		logic e_out;
	} dp_cmd_t;

	typedef struct packed {
		logic p1_done;
		logic div_busy;
		logic sqrt_busy;
		logic out_free;
		logic e_last;
	} dp_status_t;

endpackage

/* sv/instance_normalization.sv */
// Top level of the instance normalization block.
// Samples of one instance are taken one per cycle while the block is idle and
// are stored in an on-chip buffer of MAX_FEATURES entries; samples beyond that
// are dropped. The transfer flagged last_of_instance starts the processing of
// an instance of n samples: a pipelined sum-of-squares pass, a variance
// division, a square root and the denominator, then one division per result
// on the shared one-bit-per-cycle divider (a result whose quotient overflows
// skips the bit-by-bit division). New samples are taken again only once every
// result has entered the output register, where a result may wait to be taken.
// Results leave through that output register, so the next instance can start
// loading while the final result still waits to be taken. The epsilon register
// may be written at any time the block is idle.
module instance_normalization #(
	parameter int unsigned MAX_FEATURES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  inorm_pkg::sample_item_t     sample_item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output inorm_pkg::result_item_t     result_item,
	input  logic                        eps_valid,
	output logic                        eps_ready,
	input  logic [inorm_pkg::EPS_W-1:0] eps_data
);
	import inorm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign eps_ready = 1'b1;

	inorm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_last  (sample_item.last_of_instance),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	inorm_dp #(
		.MAX_FEATURES (MAX_FEATURES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample_item  (sample_item),
		.eps_we       (eps_valid),
		.eps_data     (eps_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);
endmodule

/* sv/inorm_ram.sv */
// Generic single write port RAM with one registered read port.
module inorm_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* sv/inorm_div.sv */
// Restoring divider that produces one quotient bit per cycle and flags overflow.
module inorm_div #(
	parameter int unsigned DVD_W = 53,
	parameter int unsigned DVS_W = 40,
	parameter int unsigned QW    = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [QW-1:0]    quot,
	output logic             ovf
);
	localparam int unsigned CNT_W = $clog2(QW + 1);

	logic [DVS_W:0]   rem_q;
	logic [QW-1:0]    low_q;
	logic [QW-1:0]    quot_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             ovf_q;
	logic [DVS_W:0]   hi_c;
	logic [DVS_W:0]   trial_c;
	logic             take_c;

	assign hi_c    = (DVS_W+1)'(dividend[DVD_W-1:QW]);
	assign trial_c = {rem_q[DVS_W-1:0], low_q[QW-1]};
	assign take_c  = trial_c >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (start) begin
			if (hi_c >= {1'b0, divisor}) begin
				ovf_q  <= 1'b1;
				busy_q <= 1'b0;
			end else begin
				ovf_q  <= 1'b0;
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QW);
			end
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= cnt_q != CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= hi_c;
			low_q  <= dividend[QW-1:0];
			dvs_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= take_c ? (trial_c - {1'b0, dvs_q}) : trial_c;
			low_q  <= {low_q[QW-2:0], 1'b0};
			quot_q <= {quot_q[QW-2:0], take_c};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
	assign ovf  = ovf_q;
endmodule

/* sv/inorm_sqrt.sv */
// Digit-by-digit integer square root that resolves one root bit per cycle.
module inorm_sqrt #(
	parameter int unsigned RW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RW-1:0] radicand,
	output logic            busy,
	output logic [RW-1:0]   root
);
	localparam int unsigned CNT_W = $clog2(RW + 1);

	logic [RW+1:0]    rem_q;
	logic [2*RW-1:0]  rad_q;
	logic [RW-1:0]    root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [RW+1:0]    t_c;
	logic [RW+1:0]    trial_c;
	logic             take_c;

	assign t_c     = {rem_q[RW-1:0], rad_q[2*RW-1:2*RW-2]};
	assign trial_c = {root_q, 2'b01};
	assign take_c  = t_c >= trial_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(RW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= cnt_q != CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			rad_q  <= radicand;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q  <= take_c ? (t_c - trial_c) : t_c;
			rad_q  <= {rad_q[2*RW-3:0], 2'b00};
			root_q <= {root_q[RW-2:0], take_c};
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule

/* sv/inorm_dp.sv */
// Datapath: sample buffer, running sum, variance, root and output arithmetic.
module inorm_dp #(
	parameter int unsigned MAX_FEATURES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  inorm_pkg::dp_cmd_t        cmd,
	output inorm_pkg::dp_status_t     status,
	input  inorm_pkg::sample_item_t   sample_item,
	input  logic                      eps_we,
	input  logic [inorm_pkg::EPS_W-1:0] eps_data,
	output logic                      result_valid,
	input  logic                      result_stall,
	output inorm_pkg::result_item_t   result_item
);
	import inorm_pkg::*;

	localparam int unsigned AW     = $clog2(MAX_FEATURES);
	localparam int unsigned CW     = $clog2(MAX_FEATURES + 1);
	localparam int unsigned SUM_W  = DATA_W + AW;
	localparam int unsigned D_W    = SUM_W + 1;
	localparam int unsigned SQ_W   = 2 * D_W;
	localparam int unsigned SSQ_W  = SQ_W + CW;
	localparam int unsigned NUM_W  = DATA_W + D_W;
	localparam int unsigned DVD_A  = NUM_W + FRAC_SHIFT + 2;
	localparam int unsigned DVD_W  = (DVD_A > SSQ_W) ? DVD_A : SSQ_W;
	localparam int unsigned DEN_W  = CW + ROOT_W;
	localparam int unsigned DVS_W  = (DEN_W + 1 > 3 * CW) ? DEN_W + 1 : 3 * CW;
	localparam int unsigned RAD_W  = 2 * ROOT_W;
	localparam int unsigned W_W    = QUOT_W + 1;
	localparam int unsigned Y_W    = QCLAMP_W + 2;

	logic [CW-1:0]              count_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [DATA_W-1:0]   gam_q;
	logic signed [DATA_W-1:0]   bet_q;
	logic [EPS_W-1:0]           eps_q;
	logic [CW-1:0]              idx_q;
	logic                       v_s1_q, v_s2_q, v_s3_q;
	logic signed [D_W-1:0]      d_s2;
	logic [SQ_W-1:0]            sq_s3;
	logic [SSQ_W-1:0]           acc_q;
	logic [2*CW-1:0]            nsq_q;
	logic signed [NUM_W-1:0]    num_q;
	logic [DEN_W-1:0]           den_q;
	logic                       out_valid_q;
	result_item_t               out_q;

	logic                       room_c;
	logic                       p1_issue_c;
	logic                       rd_en_c;
	logic [DATA_W-1:0]          rd_data;
	logic signed [CW+DATA_W:0]  nx_c;
	logic signed [D_W-1:0]      d_c;
	logic [3*CW-1:0]            n3_c;
	logic [NUM_W-1:0]           mag_c;
	logic [DVD_A-1:0]           dvd_e_c;
	logic                       div_start_c;
	logic [DVD_W-1:0]           div_dvd_c;
	logic [DVS_W-1:0]           div_dvs_c;
	logic                       div_busy, div_ovf;
	logic [QUOT_W-1:0]          div_quot;
	logic [W_W-1:0]             w_c;
	logic [RAD_W-1:0]           rad_c;
	logic                       sqrt_busy;
	logic [ROOT_W-1:0]          root;
	logic [ROOT_W-1:0]          root_fix_c;
	logic [QCLAMP_W-1:0]        q_c;
	logic signed [Y_W-1:0]      y_c;
	logic signed [DATA_W-1:0]   sat_c;
	logic                       out_free_c;
	logic                       e_last_c;

	assign room_c     = count_q < CW'(MAX_FEATURES);
	assign p1_issue_c = cmd.p1_run && (idx_q != count_q);
	assign rd_en_c    = p1_issue_c || cmd.e_rd;

	inorm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_FEATURES)
	) u_buf (
		.clk   (clk),
		.we    (cmd.load && room_c),
		.waddr (count_q[AW-1:0]),
		.wdata (sample_item.sample),
		.re    (rd_en_c),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	assign nx_c = $signed({1'b0, count_q}) * $signed(rd_data);
	assign d_c  = D_W'(nx_c) - D_W'(sum_q);
	assign n3_c = (3*CW)'(nsq_q) * (3*CW)'(count_q);

	assign mag_c   = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign dvd_e_c = DVD_A'({mag_c, {(FRAC_SHIFT + 1){1'b0}}}) + DVD_A'(den_q);

	assign div_start_c = cmd.var_start || cmd.e_div;
	assign div_dvd_c   = cmd.var_start ? DVD_W'(acc_q) : DVD_W'(dvd_e_c);
	assign div_dvs_c   = cmd.var_start ? DVS_W'(n3_c) : DVS_W'({den_q, 1'b0});

	inorm_div #(
		.DVD_W (DVD_W),
		.DVS_W (DVS_W),
		.QW    (QUOT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_c),
		.dividend (div_dvd_c),
		.divisor  (div_dvs_c),
		.busy     (div_busy),
		.quot     (div_quot),
		.ovf      (div_ovf)
	);

	assign w_c   = W_W'(div_quot) + W_W'(eps_q);
	assign rad_c = RAD_W'({w_c, {SQRT_SHIFT{1'b0}}});

	inorm_sqrt #(
		.RW (ROOT_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (rad_c),
		.busy     (sqrt_busy),
		.root     (root)
	);

	assign root_fix_c = (root == '0) ? ROOT_W'(1) : root;

	assign q_c   = (div_ovf || (div_quot > QUOT_W'(Q_CLAMP))) ? Q_CLAMP
		: div_quot[QCLAMP_W-1:0];
	assign y_c   = (num_q[NUM_W-1] ? -$signed(Y_W'(q_c)) : $signed(Y_W'(q_c)))
		+ Y_W'(bet_q);
	assign sat_c = (y_c > Y_W'(SAT_MAX)) ? SAT_MAX
		: (y_c < Y_W'(SAT_MIN)) ? SAT_MIN : DATA_W'(y_c);

	assign out_free_c = !out_valid_q || !result_stall;
	assign e_last_c   = (idx_q + CW'(1)) == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_q       <= '0;
			eps_q       <= EPS_RESET;
			idx_q       <= '0;
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			v_s3_q      <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (eps_we) begin
				eps_q <= eps_data;
			end
			v_s1_q <= p1_issue_c;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
			if (v_s3_q) begin
				acc_q <= acc_q + SSQ_W'(sq_s3);
			end
			if (cmd.load) begin
				if (room_c) begin
					count_q <= count_q + CW'(1);
					sum_q   <= sum_q + SUM_W'(sample_item.sample);
				end
				if (sample_item.last_of_instance) begin
					idx_q <= '0;
					acc_q <= '0;
				end
			end
			if (p1_issue_c) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.den_load) begin
				idx_q <= '0;
			end
			if (cmd.e_out) begin
				idx_q       <= idx_q + CW'(1);
				out_valid_q <= 1'b1;
				if (e_last_c) begin
					count_q <= '0;
					sum_q   <= '0;
				end
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		nsq_q <= count_q * count_q;
		if (cmd.load && sample_item.last_of_instance) begin
			gam_q <= sample_item.scale_gamma;
			bet_q <= sample_item.shift_beta;
		end
		if (v_s1_q || cmd.e_d) begin
			d_s2 <= d_c;
		end
		if (v_s2_q) begin
			sq_s3 <= SQ_W'(d_s2 * d_s2);
		end
		if (cmd.e_num) begin
			num_q <= NUM_W'(gam_q) * NUM_W'(d_s2);
		end
		if (cmd.den_load) begin
			den_q <= DEN_W'(count_q) * DEN_W'(root_fix_c);
		end
		if (cmd.e_out) begin
			out_q.norm_value  <= sat_c;
			out_q.last_in_run <= e_last_c;
		end
	end

	assign status.p1_done   = (idx_q == count_q) && !v_s1_q && !v_s2_q && !v_s3_q;
	assign status.div_busy  = div_busy;
	assign status.sqrt_busy = sqrt_busy;
	assign status.out_free  = out_free_c;
	assign status.e_last    = e_last_c;

	assign result_valid = out_valid_q;
	assign result_item  = out_q;
endmodule

/* sv/inorm_ctrl.sv */
// Controller state machine that sequences loading, statistics and output passes.
module inorm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	input  logic                  sample_last,
	output logic                  sample_stall,
	input  inorm_pkg::dp_status_t status,
	output inorm_pkg::dp_cmd_t    cmd
);
	import inorm_pkg::*;

	`include "instance_normalization_macros.svh"

	state_t state_q, state_d;
	logic   accept_c;

	assign accept_c = sample_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept_c && sample_last) state_d = ST_P1;
			ST_P1:    if (status.p1_done) state_d = ST_DIVV;
			ST_DIVV:  state_d = ST_VWAIT;
			ST_VWAIT: if (!status.div_busy) state_d = ST_SQRT;
			ST_SQRT:  state_d = ST_SWAIT;
			ST_SWAIT: if (!status.sqrt_busy) state_d = ST_DEN;
			ST_DEN:   state_d = ST_ERD;
			ST_ERD:   state_d = ST_ERAM;
			ST_ERAM:  state_d = ST_ENUM;
			ST_ENUM:  state_d = ST_EDIV;
			ST_EDIV:  state_d = ST_EWAIT;
			ST_EWAIT: if (!status.div_busy) state_d = ST_EOUT;
			ST_EOUT: begin
				if (status.out_free) begin
					state_d = status.e_last ? ST_IDLE : ST_ERD;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		sample_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				cmd.load     = accept_c;
			end
			ST_P1:   cmd.p1_run     = 1'b1;
			ST_DIVV: cmd.var_start  = 1'b1;
			ST_SQRT: cmd.sqrt_start = 1'b1;
			ST_DEN:  cmd.den_load   = 1'b1;
			ST_ERD:  cmd.e_rd       = 1'b1;
			ST_ERAM: cmd.e_d        = 1'b1;
			ST_ENUM: cmd.e_num      = 1'b1;
			ST_EDIV: cmd.e_div      = 1'b1;
			ST_EOUT: cmd.e_out      = status.out_free;
			default: cmd = '0;
		endcase
	end

	`INORM_ASSERT(a_out_wait, clk, arst_n,
		(state_q == ST_EOUT && !status.out_free) |=> (state_q == ST_EOUT),
		"Output transfer skipped while the output register was held")
	`INORM_ASSERT(a_div_idle, clk, arst_n,
		(cmd.e_div || cmd.var_start) |-> !status.div_busy,
		"Divider started while still busy")
	`INORM_ASSERT(a_sqrt_idle, clk, arst_n,
		cmd.sqrt_start |-> (!status.sqrt_busy && !status.div_busy),
		"Square root started before its operand was ready")
endmodule
